[hdl/ffac_pkg.sv]
// shared constants and register codes of the feedforward audio compressor
package ffac_pkg;

  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = 16;
  localparam int unsigned THR_W        = 15;
  // threshold is given against a 16-bit reference sample
  localparam int unsigned THR_REF_BITS = 16;
  // envelope carries the magnitude with this many extra fraction bits
  localparam int unsigned ENV_SHIFT    = 8;
  // ratio is unsigned Q8.8
  localparam int unsigned RATIO_FRAC   = 8;
  localparam logic [CFG_DATA_W-1:0] RATIO_ONE = 16'd256;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD = 3'd0,
    REG_RATIO     = 3'd1,
    REG_ATTACK    = 3'd2,
    REG_RELEASE   = 3'd3,
    REG_SMOOTH    = 3'd4
  } cfg_reg_e;

  localparam logic [THR_W-1:0]      THRESHOLD_RST = 15'd9830;
  localparam logic [CFG_DATA_W-1:0] RATIO_RST     = 16'd1024;
  localparam logic [CFG_DATA_W-1:0] ATTACK_RST    = 16'd45875;
  localparam logic [CFG_DATA_W-1:0] RELEASE_RST   = 16'd62259;
  localparam logic [CFG_DATA_W-1:0] SMOOTH_RST    = 16'd52429;

endpackage

[hdl/feedforward_audio_compressor_unit.sv]
// Feedforward peak compressor with a bit-serial multiply-accumulate unit and a bit-serial
// divider. One sample is in work at a time: the envelope update, the gain smoothing and the
// output product each run on the shared MAC, and when the envelope is above the threshold
// and the ratio is at least one, two divisions run between the envelope update and the
// gain smoothing. The next sample is taken while a result waits in the output register.
// Configuration is written with cfg_ready_o always high and must only be written while idle.
module feedforward_audio_compressor_unit
  import ffac_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned COEF_BITS   = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_in_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [SAMPLE_BITS-1:0] sample_out_o,
  output logic [COEF_BITS:0]            current_gain_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [CFG_DATA_W-1:0]         cfg_data_i
);

  localparam int unsigned SB    = SAMPLE_BITS;
  localparam int unsigned CB    = COEF_BITS;
  localparam int unsigned EW    = SB + ENV_SHIFT;
  localparam int unsigned GW    = CB + 1;
  localparam int unsigned PW    = (EW > GW) ? EW : GW;
  localparam int unsigned ACC_W = PW + GW + 1;
  localparam int unsigned QW    = (EW > GW) ? EW : GW;
  localparam int unsigned DCW   = $clog2(QW + 1);
  localparam int unsigned RQ_W  = ACC_W - CB;

  localparam logic [GW-1:0]    GAIN_ONE = {1'b1, {CB{1'b0}}};
  localparam logic [ACC_W-1:0] HALF     = ACC_W'(1) << (CB - 1);
  localparam logic [RQ_W-1:0]  MAG_LIM  = RQ_W'(1) << (SB - 1);
  localparam logic [SB-1:0]    SMAX     = {1'b0, {(SB-1){1'b1}}};
  localparam logic [SB-1:0]    SMIN     = {1'b1, {(SB-1){1'b0}}};

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ENV  = 3'd1;
  localparam logic [2:0] S_CMP  = 3'd2;
  localparam logic [2:0] S_DIV1 = 3'd3;
  localparam logic [2:0] S_DIV2 = 3'd4;
  localparam logic [2:0] S_GAIN = 3'd5;
  localparam logic [2:0] S_MULS = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  // configuration registers
  logic [THR_W-1:0]      thr_q;
  logic [CFG_DATA_W-1:0] ratio_q, atk_q, rel_q, smo_q;
  logic [CB-1:0]         atk_c, rel_c, smo_c;
  logic [EW-1:0]         thr_al;

  logic [2:0]    state_q, state_d;
  logic [EW-1:0] env_q, env_d;
  logic [GW-1:0] gain_q, gain_d;
  logic [SB-1:0] mag_q, mag_d;
  logic          neg_q, neg_d;

  logic          out_valid_q, out_valid_d;
  logic [SB-1:0] sample_out_q, sample_out_d;
  logic [GW-1:0] gain_out_q, gain_out_d;

  logic [SB-1:0] raw, mag_in;
  logic [EW-1:0] level_in;
  logic          rising;

  logic             mac_start, mac_busy;
  logic [GW-1:0]    mac_m1, mac_m2;
  logic [PW-1:0]    mac_a, mac_b;
  logic [ACC_W-1:0] mac_acc, mac_rnd;
  logic [EW-1:0]    env_new;
  logic [GW-1:0]    gain_raw, gain_new;

  logic             div_start, div_busy;
  logic [EW-1:0]    div_rem, div_dvs;
  logic [QW-1:0]    div_bits, div_quot;
  logic [DCW-1:0]   div_nbits;

  logic          compress;
  logic [EW-1:0] env_over, desired;
  logic [GW-1:0] q_gain, target;

  logic [ACC_W-1:0] y_full;
  logic [RQ_W-1:0]  y_mag;
  logic [SB-1:0]    y_sat;
  logic             out_load;

  // coefficients are the low COEF_BITS of their registers, zero-extended when COEF_BITS is wider
  if (CB >= CFG_DATA_W) begin : g_coef_wide
    assign atk_c = CB'(atk_q);
    assign rel_c = CB'(rel_q);
    assign smo_c = CB'(smo_q);
  end else begin : g_coef_narrow
    assign atk_c = atk_q[CB-1:0];
    assign rel_c = rel_q[CB-1:0];
    assign smo_c = smo_q[CB-1:0];
  end

  // threshold brought to the sample scale, then to the envelope scale
  if (SB >= THR_REF_BITS) begin : g_thr_up
    assign thr_al = EW'(thr_q) << (SB - THR_REF_BITS + ENV_SHIFT);
  end else begin : g_thr_down
    assign thr_al = EW'(thr_q >> (THR_REF_BITS - SB)) << ENV_SHIFT;
  end

  assign raw      = sample_in_i;
  assign mag_in   = raw[SB-1] ? (~raw + SB'(1)) : raw;
  assign level_in = {mag_in, {ENV_SHIFT{1'b0}}};
  assign rising   = (level_in > env_q);

  assign mac_rnd  = mac_acc + HALF;
  assign env_new  = mac_rnd[CB +: EW];
  assign gain_raw = mac_rnd[CB +: GW];
  assign gain_new = (gain_raw > GAIN_ONE) ? GAIN_ONE : gain_raw;

  assign compress = (env_q > thr_al) && (ratio_q >= RATIO_ONE);
  assign env_over = env_q - thr_al;
  assign desired  = thr_al + div_quot[EW-1:0];
  assign q_gain   = div_quot[GW-1:0];
  assign target   = (q_gain > GAIN_ONE) ? GAIN_ONE : q_gain;

  // negative products round toward zero at the half point
  assign y_full = mac_acc + HALF - ACC_W'(neg_q);
  assign y_mag  = y_full[ACC_W-1:CB];

  always_comb begin
    if (neg_q) begin
      y_sat = (y_mag > MAG_LIM) ? SMIN : (~y_mag[SB-1:0] + SB'(1));
    end else begin
      y_sat = (y_mag >= MAG_LIM) ? SMAX : y_mag[SB-1:0];
    end
  end

  assign out_load = (state_q == S_OUT) && !mac_busy && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d   = state_q;
    env_d     = env_q;
    gain_d    = gain_q;
    mag_d     = mag_q;
    neg_d     = neg_q;
    mac_start = 1'b0;
    mac_m1    = '0;
    mac_m2    = '0;
    mac_a     = '0;
    mac_b     = '0;
    div_start = 1'b0;
    div_rem   = '0;
    div_bits  = '0;
    div_nbits = '0;
    div_dvs   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          mag_d     = mag_in;
          neg_d     = raw[SB-1];
          mac_start = 1'b1;
          mac_m1    = GW'(rising ? atk_c : rel_c);
          mac_m2    = GAIN_ONE - mac_m1;
          mac_a     = PW'(env_q);
          mac_b     = PW'(level_in);
          state_d   = S_ENV;
        end
      end
      S_ENV: begin
        if (!mac_busy) begin
          env_d   = env_new;
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        if (compress) begin
          // (env - thr) * 256 / ratio: the top eight dividend bits seed the remainder
          div_start = 1'b1;
          div_rem   = EW'(env_over >> (EW - RATIO_FRAC));
          div_bits  = QW'({env_over[EW-RATIO_FRAC-1:0], {RATIO_FRAC{1'b0}}}) << (QW - EW);
          div_nbits = DCW'(EW);
          div_dvs   = EW'(ratio_q);
          state_d   = S_DIV1;
        end else begin
          mac_start = 1'b1;
          mac_m1    = GW'(smo_c);
          mac_m2    = GAIN_ONE - mac_m1;
          mac_a     = PW'(gain_q);
          mac_b     = PW'(GAIN_ONE);
          state_d   = S_GAIN;
        end
      end
      S_DIV1: begin
        if (!div_busy) begin
          // desired * one / env: quotient fits in COEF_BITS+1 bits as desired <= env
          div_start = 1'b1;
          div_rem   = desired >> 1;
          div_bits  = QW'({desired[0], {CB{1'b0}}}) << (QW - GW);
          div_nbits = DCW'(GW);
          div_dvs   = env_q;
          state_d   = S_DIV2;
        end
      end
      S_DIV2: begin
        if (!div_busy) begin
          mac_start = 1'b1;
          mac_m1    = GW'(smo_c);
          mac_m2    = GAIN_ONE - mac_m1;
          mac_a     = PW'(gain_q);
          mac_b     = PW'(target);
          state_d   = S_GAIN;
        end
      end
      S_GAIN: begin
        if (!mac_busy) begin
          gain_d  = gain_new;
          state_d = S_MULS;
        end
      end
      S_MULS: begin
        mac_start = 1'b1;
        mac_m1    = gain_q;
        mac_a     = PW'(mag_q);
        state_d   = S_OUT;
      end
      S_OUT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d  = out_valid_q;
    sample_out_d = sample_out_q;
    gain_out_d   = gain_out_q;
    if (out_load) begin
      out_valid_d  = 1'b1;
      sample_out_d = y_sat;
      gain_out_d   = gain_q;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      env_q       <= '0;
      gain_q      <= GAIN_ONE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      env_q       <= env_d;
      gain_q      <= gain_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q        <= mag_d;
    neg_q        <= neg_d;
    sample_out_q <= sample_out_d;
    gain_out_q   <= gain_out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= THRESHOLD_RST;
      ratio_q <= RATIO_RST;
      atk_q   <= ATTACK_RST;
      rel_q   <= RELEASE_RST;
      smo_q   <= SMOOTH_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_THRESHOLD: thr_q   <= cfg_data_i[THR_W-1:0];
        REG_RATIO:     ratio_q <= cfg_data_i;
        REG_ATTACK:    atk_q   <= cfg_data_i;
        REG_RELEASE:   rel_q   <= cfg_data_i;
        REG_SMOOTH:    smo_q   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  ffac_mac #(
    .AW(PW),
    .MW(GW)
  ) u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mac_start),
    .m1_i   (mac_m1),
    .m2_i   (mac_m2),
    .a_i    (mac_a),
    .b_i    (mac_b),
    .busy_o (mac_busy),
    .acc_o  (mac_acc)
  );

  ffac_div #(
    .RW(EW),
    .SW(QW)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .rem_i    (div_rem),
    .bits_i   (div_bits),
    .nbits_i  (div_nbits),
    .divisor_i(div_dvs),
    .busy_o   (div_busy),
    .quot_o   (div_quot)
  );

  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign sample_out_o   = sample_out_q;
  assign current_gain_o = gain_out_q;
  assign cfg_ready_o    = 1'b1;

endmodule

[hdl/ffac_mac.sv]
// serial-parallel multiply-accumulate: acc = m1*a + m2*b, one multiplier bit per cycle
module ffac_mac #(
  parameter int unsigned AW = 40,
  parameter int unsigned MW = 17
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [MW-1:0] m1_i,
  input  logic [MW-1:0] m2_i,
  input  logic [AW-1:0] a_i,
  input  logic [AW-1:0] b_i,
  output logic          busy_o,
  output logic [AW+MW:0] acc_o
);

  localparam int unsigned ACC_W = AW + MW + 1;
  localparam int unsigned CW    = $clog2(MW + 1);

  logic              busy_q, busy_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [MW-1:0]     m1_q, m1_d, m2_q, m2_d;
  logic [AW-1:0]     a_q, a_d, b_q, b_d;
  logic [ACC_W-1:0]  acc_q, acc_d;
  logic [ACC_W-1:0]  addend;

  always_comb begin
    addend = ACC_W'(m1_q[MW-1] ? a_q : '0) + ACC_W'(m2_q[MW-1] ? b_q : '0);
    busy_d = busy_q;
    cnt_d  = cnt_q;
    m1_d   = m1_q;
    m2_d   = m2_q;
    a_d    = a_q;
    b_d    = b_q;
    acc_d  = acc_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(MW);
      m1_d   = m1_i;
      m2_d   = m2_i;
      a_d    = a_i;
      b_d    = b_i;
      acc_d  = '0;
    end else if (busy_q) begin
      // msb first: shift the partial sum up and add the next digit
      acc_d  = (acc_q << 1) + addend;
      m1_d   = m1_q << 1;
      m2_d   = m2_q << 1;
      cnt_d  = cnt_q - CW'(1);
      busy_d = (cnt_q != CW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m1_q  <= m1_d;
    m2_q  <= m2_d;
    a_q   <= a_d;
    b_q   <= b_d;
    acc_q <= acc_d;
  end

  assign busy_o = busy_q;
  assign acc_o  = acc_q;

endmodule

[hdl/ffac_div.sv]
// restoring divider, one quotient bit per cycle; remainder start value must be below divisor
module ffac_div #(
  parameter int unsigned RW = 24,
  parameter int unsigned SW = 24
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [RW-1:0]          rem_i,
  input  logic [SW-1:0]          bits_i,
  input  logic [$clog2(SW+1)-1:0] nbits_i,
  input  logic [RW-1:0]          divisor_i,
  output logic                   busy_o,
  output logic [SW-1:0]          quot_o
);

  localparam int unsigned CW = $clog2(SW + 1);

  logic           busy_q, busy_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic [RW-1:0]  rem_q, rem_d, dvs_q, dvs_d;
  logic [SW-1:0]  bits_q, bits_d, quot_q, quot_d;
  logic [RW:0]    trial, trial_sub;
  logic           fits;

  always_comb begin
    // bring down the next dividend bit and try the subtraction
    trial     = {rem_q, bits_q[SW-1]};
    trial_sub = trial - {1'b0, dvs_q};
    fits      = (trial >= {1'b0, dvs_q});
    busy_d    = busy_q;
    cnt_d     = cnt_q;
    rem_d     = rem_q;
    dvs_d     = dvs_q;
    bits_d    = bits_q;
    quot_d    = quot_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = nbits_i;
      rem_d  = rem_i;
      dvs_d  = divisor_i;
      bits_d = bits_i;
      quot_d = '0;
    end else if (busy_q) begin
      rem_d  = fits ? trial_sub[RW-1:0] : trial[RW-1:0];
      bits_d = bits_q << 1;
      quot_d = {quot_q[SW-2:0], fits};
      cnt_d  = cnt_q - CW'(1);
      busy_d = (cnt_q != CW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
    bits_q <= bits_d;
    quot_q <= quot_d;
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;

endmodule

[hdl/ffac_checker.sv]
// port-level checks of the compressor, bound to the top level
module ffac_checker #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned COEF_BITS   = 16
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic signed [SAMPLE_BITS-1:0] sample_in_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic signed [SAMPLE_BITS-1:0] sample_out_o,
  input logic [COEF_BITS:0]            current_gain_o
);

  localparam logic [COEF_BITS:0] GAIN_ONE = {1'b1, {COEF_BITS{1'b0}}};

  // a stalled sample transaction holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(sample_in_i))
    else $error("stalled sample changed");

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(sample_out_o)
      && $stable(current_gain_o))
    else $error("stalled result changed");

  a_gain_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> current_gain_o <= GAIN_ONE)
    else $error("gain above unity");

  // one sample in work at a time
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second sample taken while busy");

  a_out_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a sample in work");

endmodule

bind feedforward_audio_compressor_unit ffac_checker #(
  .SAMPLE_BITS(SAMPLE_BITS),
  .COEF_BITS  (COEF_BITS)
) u_ffac_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .sample_in_i   (sample_in_i),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .sample_out_o  (sample_out_o),
  .current_gain_o(current_gain_o)
);
